[sv/modbus_rtu_register_slave_top_defines.svh]
// Assertion macros shared by the RTL.
`ifndef MODBUS_RTU_REGISTER_SLAVE_TOP_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mrs_pkg.sv]
package mrs_pkg;

    localparam int MAX_FRAME   = 256;
    localparam int REPLY_DEPTH = 256;
    localparam int BANK_DEPTH  = 256;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int MIN_FRAME   = 4;
    localparam int MAX_READ    = 125;
    localparam int MAX_WRITE   = 123;
    localparam int HDR_LEN     = 7;

    localparam logic [1:0] CMD_RX   = 2'd0;
    localparam logic [1:0] CMD_PULL = 2'd1;
    localparam logic [1:0] CMD_LWR  = 2'd2;
    localparam logic [1:0] CMD_LRD  = 2'd3;

    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] CFG_BANK_BASE  = 2'd1;
    localparam logic [1:0] CFG_BANK_SIZE  = 2'd2;

    localparam logic [2:0] ST_REPLY     = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_EXCEPTION = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT  = 8'd4;
    localparam logic [7:0] FC_WRITE_ONE   = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI = 8'd16;

    localparam logic [7:0] EXC_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_VALUE    = 8'd3;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        frame_done;
        logic [2:0]  frame_status;
        logic        local_ok;
        logic [15:0] read_value;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [15:0]        wdata;
        logic [BANK_AW-1:0] raddr;
    } t_bank_req;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic range_ok(input logic [15:0] start, input logic [6:0] cnt,
                                      input logic [15:0] base, input logic [8:0] used);
        logic [17:0] e;
        logic [17:0] l;
        e = {2'b00, start} + {11'd0, cnt};
        l = {2'b00, base} + {9'd0, used};
        return (start >= base) && (e <= l);
    endfunction

endpackage

[sv/mrs_ram.sv]
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/mrs_bank.sv]
module mrs_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrs_pkg::t_bank_req i_req,
    output logic [15:0]        o_rdata
);
    import mrs_pkg::*;

    logic [15:0]           r_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] r_vld;
    logic [15:0]           r_rd;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : 16'd0;
endmodule

[sv/modbus_rtu_register_slave_top.sv]
// Receive byte, local write, empty pull go straight to the output state; reply-byte pull and
// local read pass a memory read first. Frame end: on overflow straight to output, if dropped
// via evaluation; a reply adds the header, each register (bank, frame memory ports) and CRC.
// A result waits in the output register; the next item is taken meanwhile.
// Synchronous active-low reset: bank reads as zero, receiver and reply empty,
// slave address 1, bank base 0, bank size 256.
`include "modbus_rtu_register_slave_top_defines.svh"

module modbus_rtu_register_slave_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    input  logic [15:0] i_local_addr,
    input  logic [15:0] i_local_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic        o_frame_done,
    output logic [2:0]  o_frame_status,
    output logic        o_local_ok,
    output logic [15:0] o_read_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mrs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PULL  = 4'd1;
    localparam logic [3:0] S_LRD   = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_RREQ  = 4'd5;
    localparam logic [3:0] S_RHI   = 4'd6;
    localparam logic [3:0] S_RLO   = 4'd7;
    localparam logic [3:0] S_WA    = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;
    localparam logic [3:0] S_WC    = 4'd10;
    localparam logic [3:0] S_CRCLO = 4'd11;
    localparam logic [3:0] S_CRCHI = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam logic MODE_NONE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    logic [7:0]  r_slave_addr;
    logic [15:0] r_bank_base;
    logic [8:0]  r_bank_size;

    logic [3:0]  r_state,  n_state;
    logic [8:0]  r_rxcnt,  n_rxcnt;
    logic [15:0] r_crc,    n_crc;
    logic        r_ovf,    n_ovf;
    logic [8:0]  r_rlen,   n_rlen;
    logic [8:0]  r_ridx,   n_ridx;
    logic        r_ovalid, n_ovalid;
    t_result     r_out,    n_out;

    logic [7:0]  r_hdr [HDR_LEN];
    logic [7:0]  n_hdr [HDR_LEN];
    logic [7:0]  r_rh [6];
    logic [7:0]  n_rh [6];
    logic [8:0]  r_flen,   n_flen;
    logic        r_crc_ok, n_crc_ok;
    logic [8:0]  r_widx,   n_widx;
    logic [15:0] r_tcrc,   n_tcrc;
    logic [2:0]  r_hn,     n_hn;
    logic        r_mode,   n_mode;
    logic [2:0]  r_status, n_status;
    logic [6:0]  r_cnt,    n_cnt;
    logic [6:0]  r_i,      n_i;
    logic [7:0]  r_off,    n_off;
    logic [7:0]  r_hi,     n_hi;
    logic [7:0]  r_lo,     n_lo;
    t_result     r_res,    n_res;

    logic        fr_we;
    logic [7:0]  fr_waddr;
    logic [7:0]  fr_raddr;
    logic [7:0]  fr_rdata;
    logic        rp_we;
    logic [7:0]  rp_waddr;
    logic [7:0]  rp_wdata;
    logic [7:0]  rp_rdata;
    t_bank_req   bank_req;
    logic [15:0] bank_rdata;

    logic        emit_en;
    logic [7:0]  emit_data;

    logic [15:0] w_rx_crc;
    logic [8:0]  w_used;
    logic        w_loc_ok;
    logic [7:0]  w_loc_off;
    logic [15:0] w_start;
    logic [15:0] w_cnt16;
    logic [6:0]  w_rng_cnt;
    logic        w_rng_ok;
    logic        w_drop;
    logic [2:0]  w_drop_code;
    logic        w_exc;
    logic [7:0]  w_exc_code;
    logic        w_is_read;
    logic        w_is_one;
    logic        w_is_multi;
    logic        w_fc_read;
    logic        w_fc_multi;

    mrs_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    mrs_ram #(.WIDTH(8), .DEPTH(REPLY_DEPTH)) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (rp_we),
        .i_waddr (rp_waddr),
        .i_wdata (rp_wdata),
        .i_raddr (r_ridx[7:0]),
        .o_rdata (rp_rdata)
    );

    mrs_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bank_req),
        .o_rdata (bank_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_rx_crc  = crc_byte(r_crc, i_rx_byte);
    assign w_used    = (r_bank_size > 9'(BANK_DEPTH)) ? 9'(BANK_DEPTH) : r_bank_size;
    assign w_loc_ok  = range_ok(i_local_addr, 7'd1, r_bank_base, w_used);
    assign w_loc_off = 8'(i_local_addr - r_bank_base);
    assign w_start   = {r_hdr[2], r_hdr[3]};
    assign w_cnt16   = {r_hdr[4], r_hdr[5]};
    assign w_fc_read = (r_hdr[1] == FC_READ_HOLD) || (r_hdr[1] == FC_READ_INPUT);
    assign w_fc_multi = (r_hdr[1] == FC_WRITE_MULTI);
    assign w_rng_cnt = (w_fc_read || w_fc_multi) ? w_cnt16[6:0] : 7'd1;
    assign w_rng_ok  = range_ok(w_start, w_rng_cnt, r_bank_base, w_used);

    // frame-end decision, checks in protocol order
    always_comb begin
        w_drop      = 1'b0;
        w_drop_code = ST_DROPPED;
        w_exc       = 1'b0;
        w_exc_code  = EXC_FUNCTION;
        w_is_read   = 1'b0;
        w_is_one    = 1'b0;
        w_is_multi  = 1'b0;
        priority if (r_flen < 9'(MIN_FRAME)) begin
            w_drop = 1'b1;
        end else if (r_hdr[0] != r_slave_addr && r_hdr[0] != 8'd0) begin
            w_drop      = 1'b1;
            w_drop_code = ST_IGNORED;
        end else if (!r_crc_ok) begin
            w_drop = 1'b1;
        end else if (w_fc_read) begin
            priority if (r_hdr[0] == 8'd0) begin
                w_drop      = 1'b1;
                w_drop_code = ST_IGNORED;
            end else if (r_flen != 9'd8) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_VALUE;
            end else if (w_cnt16 == 16'd0 || w_cnt16 > 16'(MAX_READ)) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_VALUE;
            end else if (!w_rng_ok) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_ADDRESS;
            end else begin
                w_is_read = 1'b1;
            end
        end else if (r_hdr[1] == FC_WRITE_ONE) begin
            priority if (r_flen != 9'd8) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_VALUE;
            end else if (!w_rng_ok) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_ADDRESS;
            end else begin
                w_is_one = 1'b1;
            end
        end else if (w_fc_multi) begin
            priority if (r_flen < 9'd9) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_VALUE;
            end else if (w_cnt16 == 16'd0 || w_cnt16 > 16'(MAX_WRITE)
                         || {9'd0, r_hdr[6]} != {w_cnt16, 1'b0}
                         || {9'd0, r_flen} < 18'd9 + {1'b0, w_cnt16, 1'b0}) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_VALUE;
            end else if (!w_rng_ok) begin
                w_exc      = 1'b1;
                w_exc_code = EXC_ADDRESS;
            end else begin
                w_is_multi = 1'b1;
            end
        end else begin
            w_exc      = 1'b1;
            w_exc_code = EXC_FUNCTION;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rxcnt  = r_rxcnt;
        n_crc    = r_crc;
        n_ovf    = r_ovf;
        n_rlen   = r_rlen;
        n_ridx   = r_ridx;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        n_hdr    = r_hdr;
        n_rh     = r_rh;
        n_flen   = r_flen;
        n_crc_ok = r_crc_ok;
        n_widx   = r_widx;
        n_tcrc   = r_tcrc;
        n_hn     = r_hn;
        n_mode   = r_mode;
        n_status = r_status;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_off    = r_off;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_res    = r_res;

        fr_we          = 1'b0;
        fr_waddr       = r_rxcnt[7:0];
        fr_raddr       = 8'd7 + {r_i, 1'b0};
        rp_we          = 1'b0;
        rp_waddr       = r_widx[7:0];
        rp_wdata       = r_tcrc[7:0];
        bank_req.we    = 1'b0;
        bank_req.waddr = r_off + {1'b0, r_i};
        bank_req.wdata = {r_hi, fr_rdata};
        bank_req.raddr = r_off + {1'b0, r_i};
        emit_en        = 1'b0;
        emit_data      = 8'd0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res = '0;
                    unique case (i_command)
                        CMD_RX: begin
                            if (!r_rxcnt[8]) begin
                                fr_we   = 1'b1;
                                n_crc   = w_rx_crc;
                                n_rxcnt = r_rxcnt + 9'd1;
                                if (r_rxcnt < 9'(HDR_LEN)) begin
                                    n_hdr[r_rxcnt[2:0]] = i_rx_byte;
                                end
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_state = S_OUT;
                            if (i_rx_last) begin
                                n_rxcnt = 9'd0;
                                n_crc   = 16'hFFFF;
                                n_ovf   = 1'b0;
                                if (r_ovf || r_rxcnt[8]) begin
                                    n_res.frame_done   = 1'b1;
                                    n_res.frame_status = ST_OVERFLOW;
                                    n_rlen             = 9'd0;
                                    n_ridx             = 9'd0;
                                end else begin
                                    n_flen   = r_rxcnt + 9'd1;
                                    n_crc_ok = (w_rx_crc == 16'd0);
                                    n_state  = S_EVAL;
                                end
                            end
                        end
                        CMD_PULL: begin
                            n_state = (r_ridx < r_rlen) ? S_PULL : S_OUT;
                        end
                        CMD_LWR: begin
                            n_res.local_ok = w_loc_ok;
                            bank_req.we    = w_loc_ok;
                            bank_req.waddr = w_loc_off;
                            bank_req.wdata = i_local_value;
                            n_state        = S_OUT;
                        end
                        CMD_LRD: begin
                            bank_req.raddr = w_loc_off;
                            n_state        = w_loc_ok ? S_LRD : S_OUT;
                        end
                    endcase
                end
            end
            S_PULL: begin
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = rp_rdata;
                n_res.tx_last  = (r_ridx + 9'd1 == r_rlen);
                n_ridx         = r_ridx + 9'd1;
                n_state        = S_OUT;
            end
            S_LRD: begin
                n_res.local_ok   = 1'b1;
                n_res.read_value = bank_rdata;
                n_state          = S_OUT;
            end
            S_EVAL: begin
                n_res.frame_done = 1'b1;
                n_widx   = 9'd0;
                n_tcrc   = 16'hFFFF;
                n_mode   = MODE_NONE;
                n_status = ST_REPLY;
                n_off    = 8'(w_start - r_bank_base);
                n_cnt    = w_cnt16[6:0];
                n_i      = 7'd0;
                for (int k = 0; k < 6; k++) begin
                    n_rh[k] = r_hdr[k];
                end
                n_hn    = 3'd6;
                n_state = S_EMIT;
                priority if (w_drop) begin
                    n_res.frame_status = w_drop_code;
                    n_rlen             = 9'd0;
                    n_ridx             = 9'd0;
                    n_state            = S_OUT;
                end else if (w_exc) begin
                    n_status = ST_EXCEPTION;
                    n_rh[1]  = r_hdr[1] | 8'h80;
                    n_rh[2]  = w_exc_code;
                    n_hn     = 3'd3;
                end else if (w_is_read) begin
                    n_rh[2] = {w_cnt16[6:0], 1'b0};
                    n_hn    = 3'd3;
                    n_mode  = MODE_READ;
                end else if (w_is_one) begin
                    bank_req.we    = 1'b1;
                    bank_req.waddr = 8'(w_start - r_bank_base);
                    bank_req.wdata = {r_hdr[4], r_hdr[5]};
                end else if (w_is_multi) begin
                    n_state = S_WA;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_widx < {6'd0, r_hn}) begin
                    emit_en   = 1'b1;
                    emit_data = r_rh[r_widx[2:0]];
                end else if (r_mode == MODE_READ) begin
                    n_state = S_RREQ;
                end else begin
                    n_state = S_CRCLO;
                end
            end
            S_RREQ: begin
                n_state = S_RHI;
            end
            S_RHI: begin
                emit_en   = 1'b1;
                emit_data = bank_rdata[15:8];
                n_lo      = bank_rdata[7:0];
                n_state   = S_RLO;
            end
            S_RLO: begin
                emit_en   = 1'b1;
                emit_data = r_lo;
                n_i       = r_i + 7'd1;
                n_state   = (r_i + 7'd1 == r_cnt) ? S_CRCLO : S_RREQ;
            end
            S_WA: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_hi     = fr_rdata;
                fr_raddr = 8'd8 + {r_i, 1'b0};
                n_state  = S_WC;
            end
            S_WC: begin
                bank_req.we = 1'b1;
                n_i         = r_i + 7'd1;
                n_state     = (r_i + 7'd1 == r_cnt) ? S_EMIT : S_WA;
            end
            S_CRCLO: begin
                rp_we    = 1'b1;
                rp_wdata = r_tcrc[7:0];
                n_widx   = r_widx + 9'd1;
                n_state  = S_CRCHI;
            end
            S_CRCHI: begin
                rp_we              = 1'b1;
                rp_wdata           = r_tcrc[15:8];
                n_rlen             = r_widx + 9'd1;
                n_ridx             = 9'd0;
                n_res.frame_status = r_status;
                n_state            = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // reply body byte: store and fold into the reply CRC
        if (emit_en) begin
            rp_we    = 1'b1;
            rp_wdata = emit_data;
            n_widx   = r_widx + 9'd1;
            n_tcrc   = crc_byte(r_tcrc, emit_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rxcnt      <= 9'd0;
            r_crc        <= 16'hFFFF;
            r_ovf        <= 1'b0;
            r_rlen       <= 9'd0;
            r_ridx       <= 9'd0;
            r_ovalid     <= 1'b0;
            r_slave_addr <= 8'd1;
            r_bank_base  <= 16'd0;
            r_bank_size  <= 9'd256;
        end else begin
            r_state  <= n_state;
            r_rxcnt  <= n_rxcnt;
            r_crc    <= n_crc;
            r_ovf    <= n_ovf;
            r_rlen   <= n_rlen;
            r_ridx   <= n_ridx;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[7:0];
                    CFG_BANK_BASE:  r_bank_base  <= i_cfg_data;
                    CFG_BANK_SIZE:  r_bank_size  <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_hdr    <= n_hdr;
        r_rh     <= n_rh;
        r_flen   <= n_flen;
        r_crc_ok <= n_crc_ok;
        r_widx   <= n_widx;
        r_tcrc   <= n_tcrc;
        r_hn     <= n_hn;
        r_mode   <= n_mode;
        r_status <= n_status;
        r_cnt    <= n_cnt;
        r_i      <= n_i;
        r_off    <= n_off;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_res    <= n_res;
    end

    assign o_valid        = r_ovalid;
    assign o_tx_valid     = r_out.tx_valid;
    assign o_tx_byte      = r_out.tx_byte;
    assign o_tx_last      = r_out.tx_last;
    assign o_frame_done   = r_out.frame_done;
    assign o_frame_status = r_out.frame_status;
    assign o_local_ok     = r_out.local_ok;
    assign o_read_value   = r_out.read_value;

    `MRS_ASSERT_NOW(a_ridx_in_reply, i_clk, i_rst_n, 1'b1, r_ridx <= r_rlen, "pull index past reply")
    `MRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "accepted item left block idle")
    `MRS_ASSERT_NOW(a_last_has_byte, i_clk, i_rst_n, o_valid && o_tx_last, o_tx_valid, "tx_last without tx byte")
    `MRS_ASSERT_NOW(a_frame_no_tx, i_clk, i_rst_n, o_valid && o_frame_done, !o_tx_valid && !o_local_ok, "frame result mixed with other item")
endmodule

[tb/sv/modbus_rtu_register_slave_top_test.sv]
`timescale 1ns / 1ps

module modbus_rtu_register_slave_top_test;
    import mrs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [7:0]  i_rx_byte;
    logic        i_rx_last;
    logic [15:0] i_local_addr;
    logic [15:0] i_local_value;
    logic        o_valid;
    logic        i_ready;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_tx_last;
    logic        o_frame_done;
    logic [2:0]  o_frame_status;
    logic        o_local_ok;
    logic [15:0] o_read_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    modbus_rtu_register_slave_top dut (.*);

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic        last;
        logic [15:0] addr;
        logic [15:0] value;
    } t_item;

    // directed row: item plus an optional typed-in expectation
    typedef struct {
        t_item   it;
        logic    fixed;
        t_result res;
    } t_row;

    // slave image
    logic [7:0]  own_addr;
    logic [15:0] base_addr;
    logic [8:0]  size_reg;
    logic [7:0]  rx_buf [MAX_FRAME];
    logic [7:0]  reply_buf [REPLY_DEPTH];
    logic [15:0] regs [BANK_DEPTH];
    int          rx_len;
    logic [15:0] rx_crc;
    int          reply_len;
    int          reply_pos;
    logic        rx_over;

    t_result     expected_q[$];
    t_item       items_q[$];
    int          mismatches;
    int          sender_idle;
    int          receiver_idle;
    int          cycles;
    int          frames_done;
    int          bytes_pulled;
    logic        stim_done;

    int sent_count = 0;
    function automatic int items_sent();
        return sent_count;
    endfunction
    always @(posedge i_clk) if (i_valid && o_ready) sent_count <= sent_count + 1;

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        return x;
    endfunction

    function automatic int bank_used();
        return (size_reg > BANK_DEPTH) ? BANK_DEPTH : int'(size_reg);
    endfunction

    function automatic logic in_bank(int start, int cnt);
        return start >= base_addr && start + cnt <= int'(base_addr) + bank_used();
    endfunction

    function automatic int rx_word(int pos);
        return {rx_buf[pos], rx_buf[pos + 1]};
    endfunction

    function automatic void close_reply(int body);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < body; i++) c = crc_step(c, reply_buf[i]);
        reply_buf[body] = c[7:0];
        reply_buf[body + 1] = c[15:8];
        reply_len = body + 2;
        reply_pos = 0;
    endfunction

    function automatic logic [2:0] build_exception(logic [7:0] code);
        reply_buf[0] = rx_buf[0];
        reply_buf[1] = rx_buf[1] | 8'h80;
        reply_buf[2] = code;
        close_reply(3);
        return ST_EXCEPTION;
    endfunction

    function automatic logic [2:0] serve_frame(int len);
        int start;
        int cnt;
        int off;
        logic [7:0] fc;
        if (len < MIN_FRAME) return ST_DROPPED;
        if (rx_buf[0] != own_addr && rx_buf[0] != 8'd0) return ST_IGNORED;
        if (rx_crc != 16'd0) return ST_DROPPED;
        fc = rx_buf[1];
        if (fc == FC_READ_HOLD || fc == FC_READ_INPUT) begin
            if (rx_buf[0] == 8'd0) return ST_IGNORED;
            if (len != 8) return build_exception(EXC_VALUE);
            start = rx_word(2);
            cnt = rx_word(4);
            if (cnt < 1 || cnt > MAX_READ) return build_exception(EXC_VALUE);
            if (!in_bank(start, cnt)) return build_exception(EXC_ADDRESS);
            off = start - base_addr;
            reply_buf[0] = rx_buf[0];
            reply_buf[1] = fc;
            reply_buf[2] = 8'(cnt * 2);
            for (int i = 0; i < cnt; i++) begin
                reply_buf[3 + 2 * i] = regs[off + i][15:8];
                reply_buf[4 + 2 * i] = regs[off + i][7:0];
            end
            close_reply(3 + 2 * cnt);
            return ST_REPLY;
        end
        if (fc == FC_WRITE_ONE) begin
            if (len != 8) return build_exception(EXC_VALUE);
            start = rx_word(2);
            if (!in_bank(start, 1)) return build_exception(EXC_ADDRESS);
            regs[start - base_addr] = 16'(rx_word(4));
            for (int i = 0; i < 6; i++) reply_buf[i] = rx_buf[i];
            close_reply(6);
            return ST_REPLY;
        end
        if (fc == FC_WRITE_MULTI) begin
            if (len < 9) return build_exception(EXC_VALUE);
            start = rx_word(2);
            cnt = rx_word(4);
            if (cnt < 1 || cnt > MAX_WRITE || int'(rx_buf[6]) != cnt * 2 || len < 9 + cnt * 2)
                return build_exception(EXC_VALUE);
            if (!in_bank(start, cnt)) return build_exception(EXC_ADDRESS);
            off = start - base_addr;
            for (int i = 0; i < cnt; i++) regs[off + i] = 16'(rx_word(HDR_LEN + 2 * i));
            for (int i = 0; i < 6; i++) reply_buf[i] = rx_buf[i];
            close_reply(6);
            return ST_REPLY;
        end
        return build_exception(EXC_FUNCTION);
    endfunction

    function automatic t_result slave_step(t_item it);
        t_result r;
        r = '0;
        case (it.cmd)
            CMD_RX: begin
                if (rx_len < MAX_FRAME) begin
                    rx_buf[rx_len] = it.data;
                    rx_len++;
                    rx_crc = crc_step(rx_crc, it.data);
                end else begin
                    rx_over = 1'b1;
                end
                if (it.last) begin
                    r.frame_done = 1'b1;
                    r.frame_status = rx_over ? ST_OVERFLOW : serve_frame(rx_len);
                    if (r.frame_status != ST_REPLY && r.frame_status != ST_EXCEPTION)
                        reply_len = 0;
                    rx_len = 0;
                    rx_crc = 16'hFFFF;
                    rx_over = 1'b0;
                end
            end
            CMD_PULL: begin
                if (reply_pos < reply_len && reply_pos < REPLY_DEPTH) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = reply_buf[reply_pos];
                    r.tx_last = (reply_pos + 1 == reply_len);
                    reply_pos++;
                end
            end
            default: begin
                r.local_ok = in_bank(it.addr, 1);
                if (r.local_ok) begin
                    if (it.cmd == CMD_LWR) regs[it.addr - base_addr] = it.value;
                    else r.read_value = regs[it.addr - base_addr];
                end
            end
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 900000) begin
                $display("timeout with %0d results outstanding", expected_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver side: stall at random, check every result
    initial begin
        t_result got;
        t_result want;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{o_tx_valid, o_tx_byte, o_tx_last, o_frame_done, o_frame_status,
                        o_local_ok, o_read_value};
                if (got.frame_done) frames_done++;
                if (got.tx_valid) bytes_pulled++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at cycle %0d: expected %p got %p",
                                     cycles, want, got);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    task automatic send_item(t_item it, logic fixed, t_result res);
        t_result p;
        while ($urandom_range(99) < sender_idle) @(posedge i_clk);
        i_valid <= 1'b1;
        i_command <= it.cmd;
        i_rx_byte <= it.data;
        i_rx_last <= it.last;
        i_local_addr <= it.addr;
        i_local_value <= it.value;
        do @(posedge i_clk); while (!o_ready);
        p = slave_step(it);
        if (fixed && p !== res) begin
            mismatches++;
            if (mismatches <= 10) $display("table row expected %p, predictor %p", res, p);
        end
        expected_q.push_back(p);
        i_valid <= 1'b0;
        // the block is not ready in the cycle after an accept
        @(posedge i_clk);
    endtask

    task automatic send(t_item it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_cmd(logic [1:0] c, logic [7:0] d, logic l, logic [15:0] a,
                            logic [15:0] v);
        t_item it;
        it = '{c, d, l, a, v};
        send(it);
    endtask

    // well-formed frame from body bytes, optionally with a corrupted CRC
    task automatic send_frame(logic [7:0] body[$], logic bad_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (body[i]) c = crc_step(c, body[i]);
        if (bad_crc) c ^= 16'(1 << $urandom_range(15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i]) send_cmd(CMD_RX, body[i], i == body.size() - 1, 16'($urandom),
                                   16'($urandom));
    endtask

    task automatic pull_reply(int extra);
        int n;
        n = reply_len - reply_pos + extra;
        for (int i = 0; i < n; i++)
            send_cmd(CMD_PULL, 8'($urandom), 1'($urandom), 16'd0, 16'd0);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SLAVE_ADDR: own_addr = val[7:0];
            CFG_BANK_BASE:  base_addr = val;
            default:        size_reg = val[8:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_frame();
        logic [7:0] body[$];
        logic [7:0] fc;
        int start;
        int cnt;
        int pick;
        pick = $urandom_range(99);
        body.push_back(($urandom_range(9) == 0) ? 8'd0 :
                       ($urandom_range(9) == 0) ? 8'($urandom) : own_addr);
        case ($urandom_range(5))
            0, 1: fc = FC_READ_HOLD;
            2:    fc = FC_READ_INPUT;
            3:    fc = FC_WRITE_ONE;
            4:    fc = FC_WRITE_MULTI;
            default: fc = 8'($urandom);
        endcase
        body.push_back(fc);
        start = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                         : int'(base_addr) + $urandom_range(bank_used() + 2);
        start &= 16'hFFFF;
        cnt = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(1, 8);
        body.push_back(8'(start >> 8));
        body.push_back(8'(start));
        if (fc == FC_WRITE_MULTI) begin
            body.push_back(8'(cnt >> 8));
            body.push_back(8'(cnt));
            body.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'(cnt * 2));
            for (int i = 0; i < 2 * cnt && i < 240; i++) body.push_back(8'($urandom));
        end else begin
            body.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'(cnt >> 8));
            body.push_back(8'($urandom_range(9) == 0 ? $urandom : cnt));
        end
        // a few frames trimmed or padded to hit the length checks
        if (pick < 5) void'(body.pop_back());
        else if (pick < 8) body.push_back(8'($urandom));
        send_frame(body, $urandom_range(19) == 0);
        pull_reply($urandom_range(2) == 0 ? 1 : 0);
    endtask

    task automatic random_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_cmd(CMD_RX, 8'($urandom), i == n - 1 || $urandom_range(9) == 0, 16'd0,
                     16'd0);
    endtask

    task automatic random_local();
        int a;
        a = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                     : int'(base_addr) + $urandom_range(bank_used());
        send_cmd($urandom_range(1) ? CMD_LWR : CMD_LRD, 8'($urandom), 1'($urandom),
                 16'(a), 16'($urandom));
    endtask

    task automatic random_phase(int n_items);
        int sent0;
        sent0 = items_sent();
        while (items_sent() - sent0 < n_items) begin
            case ($urandom_range(9))
                0:       random_noise();
                1, 2:    random_local();
                3:       send_cmd(CMD_PULL, 8'($urandom), 1'($urandom), 16'($urandom), 16'd0);
                default: random_frame();
            endcase
        end
    endtask

    t_row table_rows[$];

    task automatic add_row(logic [1:0] c, logic [7:0] d, logic l, logic [15:0] a,
                           logic [15:0] v, logic fixed, t_result res);
        t_row r;
        r.it = '{c, d, l, a, v};
        r.fixed = fixed;
        r.res = res;
        table_rows.push_back(r);
    endtask

    initial begin
        logic [7:0] body[$];
        t_result r0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_RX;
        i_rx_byte = '0;
        i_rx_last = 1'b0;
        i_local_addr = '0;
        i_local_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SLAVE_ADDR;
        i_cfg_data = '0;
        own_addr = 8'd1;
        base_addr = 16'd0;
        size_reg = 9'd256;
        for (int i = 0; i < BANK_DEPTH; i++) regs[i] = '0;
        rx_len = 0;
        rx_crc = 16'hFFFF;
        reply_len = 0;
        reply_pos = 0;
        rx_over = 1'b0;
        mismatches = 0;
        frames_done = 0;
        bytes_pulled = 0;
        sender_idle = 0;
        receiver_idle = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table: reset values, extremes of the local port, short frame, empty pull, foreign-address frame
        r0 = '0;
        add_row(CMD_LRD, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1, '{0,0,0,0,0,1,0});
        add_row(CMD_LRD, 8'hFF, 1'b1, 16'd255, 16'hFFFF, 1'b1, '{0,0,0,0,0,1,0});
        add_row(CMD_LRD, 8'h00, 1'b0, 16'd256, 16'd0, 1'b1, r0);
        add_row(CMD_LWR, 8'h00, 1'b0, 16'd255, 16'hFFFF, 1'b1, '{0,0,0,0,0,1,0});
        add_row(CMD_LWR, 8'h00, 1'b0, 16'hFFFF, 16'hAAAA, 1'b1, r0);
        add_row(CMD_LRD, 8'h00, 1'b0, 16'd255, 16'd0, 1'b1, '{0,0,0,0,0,1,16'hFFFF});
        add_row(CMD_LWR, 8'h00, 1'b0, 16'd0, 16'h5555, 1'b0, r0);
        add_row(CMD_PULL, 8'hFF, 1'b1, 16'd0, 16'd0, 1'b1, r0);
        add_row(CMD_RX, 8'h01, 1'b0, 16'd0, 16'd0, 1'b1, r0);
        add_row(CMD_RX, 8'hFF, 1'b1, 16'd0, 16'd0, 1'b1, '{0,0,0,1,ST_DROPPED,0,0});
        add_row(CMD_RX, 8'h07, 1'b0, 16'd0, 16'd0, 1'b0, r0);
        add_row(CMD_RX, 8'h03, 1'b0, 16'd0, 16'd0, 1'b0, r0);
        add_row(CMD_RX, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, r0);
        add_row(CMD_RX, 8'h00, 1'b1, 16'd0, 16'd0, 1'b1, '{0,0,0,1,ST_IGNORED,0,0});
        foreach (table_rows[i]) send_item(table_rows[i].it, table_rows[i].fixed,
                                          table_rows[i].res);

        // every function, broadcast, exceptions, bad CRC
        send_frame('{8'd1, FC_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd2}, 1'b0); pull_reply(1);
        send_frame('{8'd1, FC_WRITE_ONE, 8'd0, 8'd5, 8'hBE, 8'hEF}, 1'b0); pull_reply(0);
        send_frame('{8'd1, FC_WRITE_MULTI, 8'd0, 8'd8, 8'd0, 8'd1, 8'd2, 8'h12, 8'h34},
                   1'b0); pull_reply(0);
        send_frame('{8'd1, FC_READ_INPUT, 8'd0, 8'd4, 8'd0, 8'd5}, 1'b0); pull_reply(0);
        send_frame('{8'd0, FC_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b0);
        send_frame('{8'd0, FC_WRITE_ONE, 8'd0, 8'd1, 8'd0, 8'd9}, 1'b0); pull_reply(0);
        send_frame('{8'd1, 8'h2B, 8'd0}, 1'b0); pull_reply(0);
        send_frame('{8'd1, FC_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd126}, 1'b0); pull_reply(0);
        send_frame('{8'd1, FC_READ_HOLD, 8'hFF, 8'hFF, 8'd0, 8'd1}, 1'b0);
        // stale reply dropped by the bad-CRC frame
        send_frame('{8'd1, FC_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b1); pull_reply(1);
        send_frame('{8'd1, FC_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd125}, 1'b0); pull_reply(0);
        // overflow: 260 bytes
        for (int i = 0; i < 260; i++)
            send_cmd(CMD_RX, 8'($urandom), i == 259, 16'd0, 16'd0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle = (ph == 0) ? 22 : (ph == 1) ? 62 : 0;
            receiver_idle = (ph == 0) ? 62 : (ph == 1) ? 22 : 0;
            case (ph)
                0: begin
                    write_reg(CFG_SLAVE_ADDR, 16'd255);
                    write_reg(CFG_BANK_BASE, 16'hFFC0);
                    write_reg(CFG_BANK_SIZE, 16'd511);
                end
                1: begin
                    write_reg(CFG_SLAVE_ADDR, 16'd0);
                    write_reg(CFG_BANK_BASE, 16'd100);
                    write_reg(CFG_BANK_SIZE, 16'd0);
                end
                default: begin
                    write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(1, 254)));
                    write_reg(CFG_BANK_BASE, 16'($urandom_range(0, 1000)));
                    write_reg(CFG_BANK_SIZE, 16'($urandom_range(1, 256)));
                end
            endcase
            random_phase(ph == 1 ? 150 : 200);
            // hold off until the block has answered everything
            while (expected_q.size() != 0) @(posedge i_clk);
            random_phase(ph == 1 ? 30 : 40);
            drain();
        end
        write_reg(CFG_SLAVE_ADDR, 16'd1);
        write_reg(CFG_BANK_BASE, 16'd0);
        write_reg(CFG_BANK_SIZE, 16'd256);
        random_phase(60);
        drain();

        $display("covered %0d items, %0d frame ends, %0d reply bytes pulled",
                 sent_count, frames_done, bytes_pulled);
        $display("local port, all functions, exceptions, overflow and four bank settings");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
